// ===== design/bpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Belief plausibility engine package
// Shared constants, payload types and command codes for the engine.
// ----------------------------------------------------------------------------
package bpe_pkg;

   // Frame and table sizing.
   localparam int MAX_SINGLETONS = 16;
   localparam int MASS_BITS      = 16;
   localparam int ADDR_W         = MAX_SINGLETONS;
   localparam int TABLE_DEPTH    = 1 << MAX_SINGLETONS;
   localparam int SUM_W          = 32;
   localparam int RATIO_W        = 17;
   localparam int FRAC_BITS      = 16;
   localparam int CFG_W          = 5;

   // Reset value of the singleton count register.
   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   // Command codes.
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_BEL   = 2'd2;
   localparam logic [1:0] CMD_PLS   = 2'd3;

   // Ratio value that stands for 1.0.
   localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [15:0] set_mask;
      logic [15:0] mass_value;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] sum_value;
      logic [31:0] total_mass;
      logic [16:0] ratio_q16;
      logic        zero_total;
   } rsp_payload_type;

   // Divider start request and completion status.
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] num;
      logic [SUM_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [RATIO_W-1:0] ratio;
   } div_rsp_type;

endpackage

// ===== design/bpe_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bpe_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port with registered read data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/bpe_divider.sv =====
// ----------------------------------------------------------------------------
// Ratio divider
// Computes floor(num * 2^16 / den), saturated at 1.0 (0 when den is zero), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module bpe_divider
   import bpe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   typedef enum logic [2:0] {
      DIV_IDLE  = 3'b001,
      DIV_CHECK = 3'b010,
      DIV_ITER  = 3'b100
   } div_state_type;

   div_state_type          state_ff, state_in;
   logic [SUM_W-1:0]       num_ff, num_in;
   logic [SUM_W-1:0]       den_ff, den_in;
   logic [SUM_W-1:0]       rem_ff, rem_in;
   logic [FRAC_BITS-1:0]   quo_ff, quo_in;
   logic [3:0]             cnt_ff, cnt_in;
   logic [RATIO_W-1:0]     ratio_ff, ratio_in;
   logic                   done_ff, done_in;
   logic [SUM_W:0]         rem_shift;
   logic                   fits;

   // One restoring step: shift the remainder and try the divisor.
   assign rem_shift = {rem_ff, 1'b0};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      ratio_in = ratio_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         DIV_IDLE: begin
            if (div_req.start) begin
               num_in   = div_req.num;
               den_in   = div_req.den;
               state_in = DIV_CHECK;
            end
         end
         DIV_CHECK: begin
            // A zero total gives ratio 0, a sum at or above the total gives 1.0.
            if (den_ff == '0) begin
               ratio_in = '0;
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end else if (num_ff >= den_ff) begin
               ratio_in = RATIO_ONE;
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end else begin
               rem_in   = num_ff;
               quo_in   = '0;
               cnt_in   = 4'(FRAC_BITS - 1);
               state_in = DIV_ITER;
            end
         end
         DIV_ITER: begin
            rem_in = fits ? SUM_W'(rem_shift - {1'b0, den_ff}) : rem_shift[SUM_W-1:0];
            quo_in = {quo_ff[FRAC_BITS-2:0], fits};
            cnt_in = cnt_ff - 4'd1;
            if (cnt_ff == '0) begin
               ratio_in = {1'b0, quo_ff[FRAC_BITS-2:0], fits};
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      ratio_ff <= ratio_in;
   end

   assign div_rsp.done  = done_ff;
   assign div_rsp.ratio = ratio_ff;

endmodule

// ===== design/belief_plausibility_engine_core.sv =====
// ----------------------------------------------------------------------------
// Belief plausibility engine core
// Mass table with running total and belief, plausibility and ratio queries.
// ----------------------------------------------------------------------------
// The engine holds one mass per subset of the frame in a single on-chip RAM
// and works on one transaction at a time. After reset it clears the whole
// RAM, one entry at a time, and holds req_stall high meanwhile. A mass write
// reads the old mass, then adjusts the running total and stores the new one
// (a write to the empty set or outside the frame is dropped). A mass read
// takes the stored mass; a belief or plausibility query walks every nonempty
// subset of the queried mask within the frame (of its complement within the
// frame for plausibility), and the RAM read port delivers one subset mass per
// cycle. The ratio of the sum to the total comes from a shift-subtract
// divide. When the total is zero or the sum reaches it, the divide is
// skipped. A finished result waits in an output register, so the next
// transaction is taken while it is still stalled.
module belief_plausibility_engine_core
   import bpe_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_payload_type  req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_payload_type  rsp_payload,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   typedef enum logic [7:0] {
      ST_CLEAR  = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_WRITE  = 8'b0000_0100,
      ST_READ   = 8'b0000_1000,
      ST_WALK   = 8'b0001_0000,
      ST_LAST   = 8'b0010_0000,
      ST_SUM    = 8'b0100_0000,
      ST_DIVIDE = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [ADDR_W-1:0]      clr_ff, clr_in;
   logic [CFG_W-1:0]       cfg_n_ff;
   logic [SUM_W-1:0]       total_ff, total_in;
   logic [ADDR_W-1:0]      addr_ff, addr_in;
   logic [MASS_BITS-1:0]   mass_ff, mass_in;
   logic [ADDR_W-1:0]      mask_ff, mask_in;
   logic [ADDR_W-1:0]      sub_ff, sub_in;
   logic                   pend_ff, pend_in;
   logic [SUM_W-1:0]       acc_ff, acc_in;
   logic                   plaus_ff, plaus_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   result_ff, result_in;
   logic                   rsp_valid_ff;
   rsp_payload_type        rsp_ff;

   logic                   accept;
   logic [31:0]            mask_wide;
   logic [31:0]            mass_wide;
   logic [ADDR_W-1:0]      req_addr;
   logic [MASS_BITS-1:0]   req_mass;
   logic [CFG_W-1:0]       n_eff;
   logic [ADDR_W-1:0]      frame;
   logic [ADDR_W-1:0]      query_set;
   logic [ADDR_W-1:0]      sub_next;
   logic                   write_ok;
   logic                   slot_free;
   logic                   load_rsp;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [MASS_BITS-1:0]   wr_data;
   logic [ADDR_W-1:0]      rd_addr;
   logic [MASS_BITS-1:0]   rd_data;
   logic [SUM_W-1:0]       rd_wide;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   // Configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_n_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         cfg_n_ff <= csr_data;
      end
   end

   // Clamp the singleton count into range and build the frame mask.
   always_comb begin
      if (cfg_n_ff == '0) begin
         n_eff = CFG_W'(1);
      end else if (cfg_n_ff > CFG_W'(MAX_SINGLETONS)) begin
         n_eff = CFG_W'(MAX_SINGLETONS);
      end else begin
         n_eff = cfg_n_ff;
      end
      for (int i = 0; i < ADDR_W; i++) begin
         frame[i] = CFG_W'(i) < n_eff;
      end
   end

   // Request fields fitted to the table index and mass widths.
   assign mask_wide = 32'(req_payload.set_mask);
   assign mass_wide = 32'(req_payload.mass_value);
   assign req_addr  = mask_wide[ADDR_W-1:0];
   assign req_mass  = mass_wide[MASS_BITS-1:0];
   assign write_ok  = (req_addr != '0) && ((req_addr & ~frame) == '0);
   assign query_set = (req_payload.cmd == CMD_PLS) ? (~req_addr & frame)
                                                   : (req_addr & frame);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Next nonempty subset of the walked mask.
   assign sub_next = (sub_ff - ADDR_W'(1)) & mask_ff;
   assign rd_wide  = SUM_W'(rd_data);

   // Output slot is free when empty or being taken this cycle.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == ST_DIVIDE) && result_ff && slot_free;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      total_in  = total_ff;
      addr_in   = addr_ff;
      mass_in   = mass_ff;
      mask_in   = mask_ff;
      sub_in    = sub_ff;
      pend_in   = pend_ff;
      acc_in    = acc_ff;
      plaus_in  = plaus_ff;
      sum_in    = sum_ff;
      result_in = result_ff;
      wr_en     = 1'b0;
      wr_addr   = addr_ff;
      wr_data   = mass_ff;
      rd_addr   = sub_ff;
      div_req   = '{start: 1'b0, num: sum_ff, den: total_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            rd_addr = req_addr;
            if (accept) begin
               addr_in  = req_addr;
               mass_in  = req_mass;
               mask_in  = query_set;
               sub_in   = query_set;
               pend_in  = 1'b0;
               acc_in   = '0;
               plaus_in = (req_payload.cmd == CMD_PLS);
               unique case (req_payload.cmd)
                  CMD_WRITE: begin
                     if (write_ok) begin
                        state_in = ST_WRITE;
                     end
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  CMD_BEL, CMD_PLS: begin
                     state_in = (query_set == '0) ? ST_SUM : ST_WALK;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_WRITE: begin
            // Old mass is on the read port: adjust the total and store.
            wr_en    = 1'b1;
            total_in = total_ff - rd_wide + SUM_W'(mass_ff);
            state_in = ST_IDLE;
         end
         ST_READ: begin
            acc_in   = rd_wide;
            state_in = ST_SUM;
         end
         ST_WALK: begin
            // Issue one subset address a cycle, add the mass read last cycle.
            rd_addr = sub_ff;
            sub_in  = sub_next;
            pend_in = 1'b1;
            if (pend_ff) begin
               acc_in = acc_ff + rd_wide;
            end
            if (sub_next == '0) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            acc_in   = acc_ff + rd_wide;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sum_in    = plaus_ff ? (total_ff - acc_ff) : acc_ff;
            result_in = 1'b0;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            // Start the divider on entry, then hold the ratio until the slot frees.
            div_req.start = !pend_ff;
            pend_in       = 1'b1;
            if (div_rsp.done) begin
               result_in = 1'b1;
            end
            if (load_rsp) begin
               result_in = 1'b0;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (state_ff == ST_SUM) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_CLEAR;
         clr_ff    <= '0;
         total_ff  <= '0;
         pend_ff   <= 1'b0;
         result_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         total_ff  <= total_in;
         pend_ff   <= pend_in;
         result_ff <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff  <= addr_in;
      mass_ff  <= mass_in;
      mask_ff  <= mask_in;
      sub_ff   <= sub_in;
      acc_ff   <= acc_in;
      plaus_ff <= plaus_in;
      sum_ff   <= sum_in;
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         priority if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff.sum_value  <= sum_ff;
         rsp_ff.total_mass <= total_ff;
         rsp_ff.ratio_q16  <= div_rsp.ratio;
         rsp_ff.zero_total <= (total_ff == '0);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Mass table.
   bpe_ram #(
      .WIDTH (MASS_BITS),
      .DEPTH (TABLE_DEPTH)
   ) u_mass_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Ratio divider.
   bpe_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule
